// File: sv/lru_buffer_pool_slot_manager_core_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the buffer pool slot manager
// ---------------------------------------------------------------------------
`ifndef LRU_BUFFER_POOL_SLOT_MANAGER_CORE_ASSERT_SVH
`define LRU_BUFFER_POOL_SLOT_MANAGER_CORE_ASSERT_SVH

// same-cycle implication
`define LRUB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define LRUB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/lrub_pkg.sv
// ---------------------------------------------------------------------------
// lrub_pkg
// Shared types and codes of the buffer pool slot manager.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package lrub_pkg;

   localparam int IDX_W   = 10;
   localparam int PAGE_W  = 32;
   localparam int STAMP_W = 32;

   localparam logic [1:0] MODE_ACCESS  = 2'd0;
   localparam logic [1:0] MODE_UNPIN   = 2'd1;
   localparam logic [1:0] MODE_RELEASE = 2'd2;
   localparam logic [1:0] MODE_NONE    = 2'd3;

   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_ALL_PINNED = 2'd1;
   localparam logic [1:0] STATUS_NOT_RES    = 2'd2;

   typedef enum logic [2:0] {
      UPD_NONE,
      UPD_HIT,
      UPD_FILL,
      UPD_UNPIN,
      UPD_RELEASE
   } upd_op_type;

   typedef struct packed {
      logic               active;
      logic [PAGE_W-1:0]  page;
      logic               found;
      logic [IDX_W-1:0]   found_idx;
      logic               free_ok;
      logic [IDX_W-1:0]   free_idx;
      logic               vic_ok;
      logic [IDX_W-1:0]   vic_idx;
      logic [STAMP_W-1:0] vic_stamp;
      logic [PAGE_W-1:0]  vic_page;
      logic               vic_dirty;
   } probe_type;

   typedef struct packed {
      upd_op_type         op;
      logic [IDX_W-1:0]   idx;
      logic [PAGE_W-1:0]  page;
      logic               pin;
      logic               wr;
      logic [STAMP_W-1:0] stamp;
   } upd_type;

   typedef struct packed {
      logic [5:0]        slot;
      logic              hit;
      logic              load_needed;
      logic              writeback_needed;
      logic [PAGE_W-1:0] victim_page;
      logic              evicted;
      logic [1:0]        status;
   } res_type;

   function automatic logic stamp_older(input logic [STAMP_W-1:0] a,
                                        input logic [STAMP_W-1:0] b);
      return {~a[STAMP_W-1], a[STAMP_W-2:0]} < {~b[STAMP_W-1], b[STAMP_W-2:0]};
   endfunction

endpackage

// File: sv/lrub_if.sv
// ---------------------------------------------------------------------------
// lrub_req_if / lrub_rsp_if
// Valid/ready channels for requests and results.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lrub_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [31:0] page_id;
   logic        pin;
   logic        write;

   modport source (output valid, mode, page_id, pin, write, input ready);
   modport sink   (input valid, mode, page_id, pin, write, output ready);
endinterface

interface lrub_rsp_if;
   logic        valid;
   logic        ready;
   logic [5:0]  slot;
   logic        hit;
   logic        load_needed;
   logic        writeback_needed;
   logic [31:0] victim_page;
   logic        evicted;
   logic [1:0]  status;

   modport source (output valid, slot, hit, load_needed, writeback_needed,
                   victim_page, evicted, status, input ready);
   modport sink   (input valid, slot, hit, load_needed, writeback_needed,
                   victim_page, evicted, status, output ready);
endinterface

// File: sv/lru_buffer_pool_slot_manager_core.sv
// ---------------------------------------------------------------------------
// lru_buffer_pool_slot_manager_core
// Buffer pool slot manager with LRU replacement and pinning.
// ---------------------------------------------------------------------------
// Requests arrive on req_ch (mode, page_id, pin, write); one result item per
// request leaves on rsp_ch. Both use valid/ready; an item moves when both
// are high at a rising clock edge.
// A request enters a row of SLOTS cells as a probe item that advances one
// cell per cycle; each cell folds in its lookup, free-slot and victim check.
// After the last cell the decision is registered, and the slot update is
// applied from the done state once the result register is free.
// One request is in flight at a time: a new request is accepted only after
// the update of the previous one has been applied.
// Reset (synchronous, active high) empties every slot, clears pins, dirty
// flags and the access clock. Page ids and stamps are not cleared.
// When rsp_ch stalls, a finished result waits in the output register; the
// next request may still be accepted and scanned, and its update waits until
// the output register frees.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lru_buffer_pool_slot_manager_core #(
   parameter int SLOTS        = 64,
   parameter int PAGE_ID_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   lrub_req_if.sink    req_ch,
   lrub_rsp_if.source  rsp_ch
);

   localparam int PW = (PAGE_ID_BITS < 32) ? PAGE_ID_BITS : 32;

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_type;

   state_type                    state_ff;
   logic [1:0]                   mode_ff;
   logic                         pin_ff, wr_ff;
   logic [lrub_pkg::STAMP_W-1:0] clock_ff;
   lrub_pkg::res_type            res_ff, res_in, rsp_ff;
   lrub_pkg::upd_type            updq_ff, updq_in, upd_bc;
   logic                         rsp_valid_ff;
   logic                         out_free, accept;
   lrub_pkg::probe_type          chain [SLOTS+1];
   lrub_pkg::probe_type          fin;
   logic [lrub_pkg::PAGE_W-1:0]  id_masked;

   assign accept    = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == S_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ch.ready;
   assign id_masked = lrub_pkg::PAGE_W'(req_ch.page_id[PW-1:0]);

   always_comb begin
      chain[0]        = '0;
      chain[0].active = accept;
      chain[0].page   = id_masked;
   end

   for (genvar g = 0; g < SLOTS; g++) begin : g_cell
      lrub_cell #(.IDX(g), .PW(PW)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .probe_in  (chain[g]),
         .probe_out (chain[g+1]),
         .upd       (upd_bc)
      );
   end

   assign fin = chain[SLOTS];

   always_comb begin
      res_in       = '0;
      updq_in      = '0;
      updq_in.op   = lrub_pkg::UPD_NONE;
      updq_in.page = fin.page;
      updq_in.pin  = pin_ff;
      updq_in.wr   = wr_ff;
      updq_in.stamp = clock_ff + 1'b1;
      priority if (mode_ff == lrub_pkg::MODE_ACCESS) begin
         priority if (fin.found) begin
            res_in.hit  = 1'b1;
            res_in.slot = fin.found_idx[5:0];
            updq_in.op  = lrub_pkg::UPD_HIT;
            updq_in.idx = fin.found_idx;
         end else if (fin.free_ok) begin
            res_in.load_needed = 1'b1;
            res_in.slot = fin.free_idx[5:0];
            updq_in.op  = lrub_pkg::UPD_FILL;
            updq_in.idx = fin.free_idx;
         end else if (fin.vic_ok) begin
            res_in.load_needed      = 1'b1;
            res_in.evicted          = 1'b1;
            res_in.victim_page      = fin.vic_page;
            res_in.writeback_needed = fin.vic_dirty;
            res_in.slot = fin.vic_idx[5:0];
            updq_in.op  = lrub_pkg::UPD_FILL;
            updq_in.idx = fin.vic_idx;
         end else begin
            res_in.status = lrub_pkg::STATUS_ALL_PINNED;
         end
      end else if (mode_ff == lrub_pkg::MODE_UNPIN || mode_ff == lrub_pkg::MODE_RELEASE) begin
         if (fin.found) begin
            res_in.hit  = 1'b1;
            res_in.slot = fin.found_idx[5:0];
            updq_in.idx = fin.found_idx;
            updq_in.op  = (mode_ff == lrub_pkg::MODE_UNPIN) ? lrub_pkg::UPD_UNPIN
                                                            : lrub_pkg::UPD_RELEASE;
         end else begin
            res_in.status = lrub_pkg::STATUS_NOT_RES;
         end
      end else begin
      end
   end

   always_comb begin
      upd_bc = updq_ff;
      if (!(state_ff == S_DONE && out_free)) begin
         upd_bc.op = lrub_pkg::UPD_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         clock_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == S_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  mode_ff  <= req_ch.mode;
                  pin_ff   <= req_ch.pin;
                  wr_ff    <= req_ch.write;
                  state_ff <= S_SCAN;
               end
            end
            S_SCAN: begin
               if (fin.active) begin
                  res_ff   <= res_in;
                  updq_ff  <= updq_in;
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (out_free) begin
                  rsp_ff <= res_ff;
                  if (updq_ff.op == lrub_pkg::UPD_HIT || updq_ff.op == lrub_pkg::UPD_FILL) begin
                     clock_ff <= updq_ff.stamp;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.slot             = rsp_ff.slot;
   assign rsp_ch.hit              = rsp_ff.hit;
   assign rsp_ch.load_needed      = rsp_ff.load_needed;
   assign rsp_ch.writeback_needed = rsp_ff.writeback_needed;
   assign rsp_ch.victim_page      = rsp_ff.victim_page;
   assign rsp_ch.evicted          = rsp_ff.evicted;
   assign rsp_ch.status           = rsp_ff.status;

`include "lru_buffer_pool_slot_manager_core_assert.svh"

   `LRUB_ASSERT_NOW(a_scan_end_in_scan, clock, reset, fin.active, state_ff == S_SCAN, "probe left the row outside scan")
   `LRUB_ASSERT_NEXT(a_accept_starts_scan, clock, reset, accept, state_ff == S_SCAN, "accepted item did not start a scan")
   `LRUB_ASSERT_NOW(a_pinned_no_load, clock, reset, rsp_valid_ff && rsp_ff.status != lrub_pkg::STATUS_OK, !rsp_ff.load_needed && !rsp_ff.hit && !rsp_ff.evicted, "error result carries slot flags")

endmodule

// File: sv/lrub_cell.sv
// ---------------------------------------------------------------------------
// lrub_cell
// One slot: holds its state, folds itself into the passing probe item.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lrub_cell #(
   parameter int IDX = 0,
   parameter int PW  = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  lrub_pkg::probe_type probe_in,
   output lrub_pkg::probe_type probe_out,
   input  lrub_pkg::upd_type   upd
);

   logic                         valid_ff, valid_in;
   logic                         pinned_ff, pinned_in;
   logic                         dirty_ff, dirty_in;
   logic [PW-1:0]                page_ff, page_in;
   logic [lrub_pkg::STAMP_W-1:0] stamp_ff, stamp_in;
   lrub_pkg::probe_type          probe_ff, probe_in_nx;
   logic                         sel;
   logic [lrub_pkg::IDX_W-1:0]   my_idx;

   assign my_idx = lrub_pkg::IDX_W'(IDX);
   assign sel    = (upd.idx == my_idx);

   always_comb begin
      probe_in_nx = probe_in;
      if (valid_ff && !probe_in.found && page_ff == probe_in.page[PW-1:0]) begin
         probe_in_nx.found     = 1'b1;
         probe_in_nx.found_idx = my_idx;
      end
      if (!valid_ff && !probe_in.free_ok) begin
         probe_in_nx.free_ok  = 1'b1;
         probe_in_nx.free_idx = my_idx;
      end
      if (valid_ff && !pinned_ff &&
          (!probe_in.vic_ok || lrub_pkg::stamp_older(stamp_ff, probe_in.vic_stamp))) begin
         probe_in_nx.vic_ok    = 1'b1;
         probe_in_nx.vic_idx   = my_idx;
         probe_in_nx.vic_stamp = stamp_ff;
         probe_in_nx.vic_page  = lrub_pkg::PAGE_W'(page_ff);
         probe_in_nx.vic_dirty = dirty_ff;
      end
   end

   always_comb begin
      valid_in  = valid_ff;
      pinned_in = pinned_ff;
      dirty_in  = dirty_ff;
      page_in   = page_ff;
      stamp_in  = stamp_ff;
      if (sel) begin
         unique case (upd.op)
            lrub_pkg::UPD_HIT: begin
               pinned_in = pinned_ff | upd.pin;
               dirty_in  = dirty_ff | upd.wr;
               stamp_in  = upd.stamp;
            end
            lrub_pkg::UPD_FILL: begin
               valid_in  = 1'b1;
               pinned_in = upd.pin;
               dirty_in  = upd.wr;
               page_in   = upd.page[PW-1:0];
               stamp_in  = upd.stamp;
            end
            lrub_pkg::UPD_UNPIN: begin
               pinned_in = 1'b0;
            end
            lrub_pkg::UPD_RELEASE: begin
               pinned_in = 1'b0;
               valid_in  = 1'b0;
               dirty_in  = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      page_ff  <= page_in;
      stamp_ff <= stamp_in;
      if (reset) begin
         valid_ff  <= 1'b0;
         pinned_ff <= 1'b0;
         dirty_ff  <= 1'b0;
         probe_ff  <= '0;
      end else begin
         valid_ff  <= valid_in;
         pinned_ff <= pinned_in;
         dirty_ff  <= dirty_in;
         probe_ff  <= probe_in_nx;
      end
   end

   assign probe_out = probe_ff;

endmodule

// File: bench/lrub_tb_if.sv
// ---------------------------------------------------------------------------
// lrub testbench constants
// The bench builds against the block's own channel interfaces in lrub_if.sv;
// this file holds the pool size shared by the bench.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package lrub_tb_pkg;
   localparam int TB_SLOTS = 64;
endpackage

// File: bench/tb_lru_buffer_pool_slot_manager_core.sv
// ---------------------------------------------------------------------------
// Buffer pool slot manager testbench
// Drives page requests with random idling and a long result stall. A
// scoreboard predicts hit, fill, eviction and pin behaviour and checks every
// result item field by field, in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_lru_buffer_pool_slot_manager_core;

   class pool_scoreboard;
      bit                occ [lrub_tb_pkg::TB_SLOTS];
      bit [31:0]         pid [lrub_tb_pkg::TB_SLOTS];
      bit                pinned [lrub_tb_pkg::TB_SLOTS];
      bit                dirty [lrub_tb_pkg::TB_SLOTS];
      bit [31:0]         stamp [lrub_tb_pkg::TB_SLOTS];
      bit [31:0]         clk_count;
      lrub_pkg::res_type pending [$];
      int                errors;

      function void note_request(logic [1:0] mode, logic [31:0] page, logic pn,
                                 logic wr);
         lrub_pkg::res_type r;
         int s;
         s = -1;
         r = '0;
         for (int i = 0; i < lrub_tb_pkg::TB_SLOTS; i++)
            if (s < 0 && occ[i] && pid[i] == page) s = i;
         if (mode == lrub_pkg::MODE_ACCESS) begin
            if (s >= 0) begin
               r.hit = 1;
               if (pn) pinned[s] = 1;
               if (wr) dirty[s] = 1;
            end else begin
               for (int i = 0; i < lrub_tb_pkg::TB_SLOTS; i++)
                  if (s < 0 && !occ[i]) s = i;
               if (s < 0) begin
                  for (int i = 0; i < lrub_tb_pkg::TB_SLOTS; i++)
                     if (occ[i] && !pinned[i] && (s < 0 ||
                         (stamp[i] ^ 32'h8000_0000) < (stamp[s] ^ 32'h8000_0000)))
                        s = i;
                  if (s >= 0) begin
                     r.evicted = 1;
                     r.victim_page = pid[s];
                     r.writeback_needed = dirty[s];
                  end
               end
               if (s >= 0) begin
                  r.load_needed = 1;
                  occ[s] = 1;
                  pid[s] = page;
                  pinned[s] = pn;
                  dirty[s] = wr;
               end
            end
            if (s >= 0) begin
               clk_count++;
               stamp[s] = clk_count;
               r.slot = s[5:0];
            end else r.status = lrub_pkg::STATUS_ALL_PINNED;
         end else if (mode == lrub_pkg::MODE_UNPIN || mode == lrub_pkg::MODE_RELEASE) begin
            if (s >= 0) begin
               r.slot = s[5:0];
               r.hit = 1;
               pinned[s] = 0;
               if (mode == lrub_pkg::MODE_RELEASE) begin
                  occ[s] = 0;
                  dirty[s] = 0;
               end
            end else r.status = lrub_pkg::STATUS_NOT_RES;
         end
         pending.push_back(r);
      endfunction

      function void check_result(lrub_pkg::res_type got);
         lrub_pkg::res_type e;
         if (pending.size() == 0) begin
            $error("result with nothing expected");
            errors++;
            return;
         end
         e = pending.pop_front();
         if (got.slot !== e.slot) begin
            $error("slot exp %0d got %0d", e.slot, got.slot); errors++;
         end
         if (got.hit !== e.hit) begin
            $error("hit exp %0d got %0d", e.hit, got.hit); errors++;
         end
         if (got.load_needed !== e.load_needed) begin
            $error("load_needed exp %0d got %0d", e.load_needed, got.load_needed);
            errors++;
         end
         if (got.writeback_needed !== e.writeback_needed) begin
            $error("writeback_needed exp %0d got %0d", e.writeback_needed,
                   got.writeback_needed);
            errors++;
         end
         if (got.victim_page !== e.victim_page) begin
            $error("victim_page exp %h got %h", e.victim_page, got.victim_page);
            errors++;
         end
         if (got.evicted !== e.evicted) begin
            $error("evicted exp %0d got %0d", e.evicted, got.evicted); errors++;
         end
         if (got.status !== e.status) begin
            $error("status exp %0d got %0d", e.status, got.status); errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   lrub_req_if req_ch ();
   lrub_rsp_if rsp_ch ();
   pool_scoreboard sb;
   bit rsp_idle_on = 1;
   bit hold_off = 0;
   bit [31:0] hot_pages [16];

   always #2 clock = ~clock;

   lru_buffer_pool_slot_manager_core #(
      .SLOTS(lrub_tb_pkg::TB_SLOTS), .PAGE_ID_BITS(32)
   ) dut (
      .clock(clock), .reset(reset), .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source)
   );

   initial begin
      req_ch.valid = 0;
      req_ch.mode = lrub_pkg::MODE_ACCESS;
      req_ch.page_id = 0;
      req_ch.pin = 0;
      req_ch.write = 0;
      rsp_ch.ready = 0;
   end

   // result side: random ready, hold off on request
   always @(posedge clock) begin
      if (reset) rsp_ch.ready <= 0;
      else if (hold_off) rsp_ch.ready <= 0;
      else rsp_ch.ready <= rsp_idle_on ? ($urandom_range(99) >= 19) : 1'b1;
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         sb.check_result({rsp_ch.slot, rsp_ch.hit, rsp_ch.load_needed,
                          rsp_ch.writeback_needed, rsp_ch.victim_page,
                          rsp_ch.evicted, rsp_ch.status});
   end

   task automatic send_item(logic [1:0] mode, logic [31:0] page, logic pn,
                            logic wr, bit idle);
      if (idle)
         while ($urandom_range(99) < 19) begin
            req_ch.valid <= 0;
            @(posedge clock);
         end
      req_ch.valid <= 1;
      req_ch.mode <= mode;
      req_ch.page_id <= page;
      req_ch.pin <= pn;
      req_ch.write <= wr;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_request(mode, page, pn, wr);
   endtask

   function automatic bit [31:0] pick_page();
      int k;
      k = $urandom_range(99);
      if (k < 70) return hot_pages[$urandom_range(15)] + $urandom_range(79);
      return $urandom();
   endfunction

   task automatic random_item(bit idle);
      int k;
      logic [1:0] m;
      k = $urandom_range(99);
      m = (k < 70) ? lrub_pkg::MODE_ACCESS : (k < 85) ? lrub_pkg::MODE_UNPIN
                                                      : lrub_pkg::MODE_RELEASE;
      send_item(m, pick_page(), $urandom_range(99) < 20, 1'($urandom_range(1)), idle);
   endtask

   initial begin
      int n;
      sb = new();
      for (int i = 0; i < 16; i++) hot_pages[i] = $urandom();
      hot_pages[0] = 0;
      hot_pages[1] = 32'hFFFF_FF00;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: extremes, not-resident, hits, unused mode, all pinned
      send_item(lrub_pkg::MODE_UNPIN, 32'h0, 0, 0, 0);
      send_item(lrub_pkg::MODE_RELEASE, 32'hFFFF_FFFF, 0, 0, 0);
      send_item(lrub_pkg::MODE_ACCESS, 32'h0, 0, 1, 0);
      send_item(lrub_pkg::MODE_ACCESS, 32'hFFFF_FFFF, 1, 0, 0);
      send_item(lrub_pkg::MODE_ACCESS, 32'h0, 1, 0, 0);
      send_item(lrub_pkg::MODE_ACCESS, 32'hFFFF_FFFF, 0, 1, 0);
      send_item(lrub_pkg::MODE_UNPIN, 32'hFFFF_FFFF, 0, 0, 0);
      send_item(lrub_pkg::MODE_RELEASE, 32'h0, 0, 0, 0);
      send_item(lrub_pkg::MODE_NONE, 32'hA5A5_5A5A, 1, 1, 0);
      // fill with pinned pages then ask once more: all pinned
      for (int i = 0; i < lrub_tb_pkg::TB_SLOTS; i++)
         send_item(lrub_pkg::MODE_ACCESS, 32'h1000 + i, 1, i[0], 1);
      send_item(lrub_pkg::MODE_ACCESS, 32'h5555_AAAA, 0, 0, 0);
      for (int i = 0; i < lrub_tb_pkg::TB_SLOTS; i++)
         send_item(lrub_pkg::MODE_UNPIN, 32'h1000 + i, 0, 0, 1);
      // long result stall while requests keep coming
      fork
         begin
            hold_off = 1;
            repeat (600) @(posedge clock);
            hold_off = 0;
         end
         repeat (6) random_item(0);
      join
      // random, with one stretch without idling
      n = 0;
      while (n < 1250) begin
         rsp_idle_on = !(n >= 500 && n < 700);
         if ($urandom_range(99) < 2)
            send_item(lrub_pkg::MODE_NONE, $urandom(), 1'($urandom_range(1)),
                      1'($urandom_range(1)), rsp_idle_on);
         else random_item(rsp_idle_on);
         n++;
      end
      req_ch.valid <= 0;
      rsp_idle_on = 1;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (lrub_tb_pkg::TB_SLOTS * 3) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("PASS lru_buffer_pool_slot_manager_core");
      else
         $display("FAIL lru_buffer_pool_slot_manager_core");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("FAIL lru_buffer_pool_slot_manager_core");
      $finish;
   end
endmodule
